### rtl/click_double_click_classifier_top_defines.svh
// assertion macros used by the classifier back end
`ifndef CLICK_DOUBLE_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define CLICK_DOUBLE_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define CDCC_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdcc check failed");

// next-cycle implication, checked on clk, off while rst_n is low
`define CDCC_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdcc check failed");

`endif

### rtl/cdcc_pkg.sv
// types, constants and codes of the click and double click classifier
`default_nettype none

package cdcc_pkg;

  localparam int KEY_SLOTS  = 512;
  localparam int SLOT_BITS  = $clog2(KEY_SLOTS);
  localparam int TIME_BITS  = 32;
  localparam int KEY_BITS   = 9;
  localparam int MOD_BITS   = 4;
  localparam int POS_BITS   = 16;
  localparam int TICK_BITS  = 16;
  localparam int D2_BITS    = 2 * POS_BITS + 2;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = RES_PTR_BITS + 1;

  // input command codes
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_REPEAT  = 2'd2;

  // register indexes (word address)
  localparam logic [2:0] REG_LISTENING    = 3'd0;
  localparam logic [2:0] REG_KEY_CLICK    = 3'd1;
  localparam logic [2:0] REG_MOUSE_CLICK  = 3'd2;
  localparam logic [2:0] REG_DOUBLE_CLICK = 3'd3;
  localparam logic [2:0] REG_RADIUS_SQ    = 3'd4;

  typedef enum logic [1:0] {
    OP_PRESS,
    OP_RELEASE,
    OP_REPEAT
  } op_kind_t;

  typedef enum logic [1:0] {
    EV_DOWN,
    EV_RELEASE,
    EV_CLICK,
    EV_DOUBLE
  } ev_kind_t;

  typedef struct packed {
    op_kind_t                     kind;
    logic                         mouse;
    logic [KEY_BITS-1:0]          key;
    logic [MOD_BITS-1:0]          mods;
    logic [TIME_BITS-1:0]         now;
    logic signed [POS_BITS-1:0]   cx;
    logic signed [POS_BITS-1:0]   cy;
  } op_t;

  typedef struct packed {
    ev_kind_t             kind;
    logic [KEY_BITS-1:0]  key;
    logic [MOD_BITS-1:0]  mods;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] key_click;
    logic [TICK_BITS-1:0] mouse_click;
    logic [TICK_BITS-1:0] dbl_click;
    logic [TICK_BITS-1:0] radius_sq;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/cdcc_ram.sv
// single write port, single read port ram with registered read and write-first bypass
`default_nettype none

module cdcc_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 512,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/cdcc_front.sv
// front end: accepts input words, drops ignored events, queues decoded ops
`default_nettype none

module cdcc_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [1:0]                          in_cmd,
  input  wire logic                                in_from_mouse,
  input  wire logic [cdcc_pkg::KEY_BITS-1:0]       in_key_code,
  input  wire logic [cdcc_pkg::MOD_BITS-1:0]       in_modifiers,
  input  wire logic [cdcc_pkg::TIME_BITS-1:0]      in_now_ticks,
  input  wire logic signed [cdcc_pkg::POS_BITS-1:0] in_cursor_x,
  input  wire logic signed [cdcc_pkg::POS_BITS-1:0] in_cursor_y,
  input  wire logic                                listening,
  input  wire logic                                clr_busy,
  input  wire logic                                op_pop,
  output logic                                     op_valid,
  output cdcc_pkg::op_t                            op_head
);

  cdcc_pkg::op_t q_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          accept;
  logic          keep;
  logic          wr;
  logic          rd;
  cdcc_pkg::op_t op_new;

  always_comb begin
    keep        = 1'b0;
    op_new.kind = cdcc_pkg::OP_PRESS;
    case (in_cmd)
      cdcc_pkg::CMD_PRESS: begin
        keep        = 1'b1;
        op_new.kind = cdcc_pkg::OP_PRESS;
      end
      cdcc_pkg::CMD_RELEASE: begin
        keep        = 1'b1;
        op_new.kind = cdcc_pkg::OP_RELEASE;
      end
      cdcc_pkg::CMD_REPEAT: begin
        // mouse repeat gives nothing
        keep        = !in_from_mouse;
        op_new.kind = cdcc_pkg::OP_REPEAT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    op_new.mouse = in_from_mouse;
    op_new.key   = in_key_code;
    op_new.mods  = in_modifiers;
    op_new.now   = in_now_ticks;
    op_new.cx    = in_cursor_x;
    op_new.cy    = in_cursor_y;
  end

  assign full   = (cnt_r == 2'd2) || clr_busy;
  assign accept = push && !full;
  assign wr     = accept && keep && listening;
  assign rd     = op_pop && (cnt_r != 2'd0);

  always_comb begin
    wp_nxt  = wr ? !wp_r : wp_r;
    rp_nxt  = rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= op_new;
    end
  end

  assign op_valid = (cnt_r != 2'd0);
  assign op_head  = q_r[rp_r];

endmodule

`default_nettype wire

### rtl/cdcc_res_queue.sv
// result queue: takes up to two words a cycle, hands out one
`default_nettype none

module cdcc_res_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               push0,
  input  wire logic                               push1,
  input  wire cdcc_pkg::res_t                     res0,
  input  wire cdcc_pkg::res_t                     res1,
  input  wire logic                               pop,
  output logic                                    empty,
  output cdcc_pkg::res_t                          head,
  output logic [cdcc_pkg::RES_CNT_BITS-1:0]       free
);

  cdcc_pkg::res_t                      mem_r [cdcc_pkg::RES_DEPTH];
  logic [cdcc_pkg::RES_PTR_BITS-1:0]   wp_r, wp_nxt;
  logic [cdcc_pkg::RES_PTR_BITS-1:0]   rp_r, rp_nxt;
  logic [cdcc_pkg::RES_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [cdcc_pkg::RES_PTR_BITS-1:0]   wp_1;
  logic                                rd;

  assign empty = (cnt_r == '0);
  assign rd    = pop && !empty;
  assign wp_1  = wp_r + cdcc_pkg::RES_PTR_BITS'(1);

  always_comb begin
    wp_nxt  = wp_r + cdcc_pkg::RES_PTR_BITS'(push0) + cdcc_pkg::RES_PTR_BITS'(push1);
    rp_nxt  = rp_r + cdcc_pkg::RES_PTR_BITS'(rd);
    cnt_nxt = cnt_r + cdcc_pkg::RES_CNT_BITS'(push0) + cdcc_pkg::RES_CNT_BITS'(push1)
            - cdcc_pkg::RES_CNT_BITS'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wp_r] <= res0;
    end
    if (push1) begin
      mem_r[wp_1] <= res1;
    end
  end

  assign head = mem_r[rp_r];
  assign free = cdcc_pkg::RES_CNT_BITS'(cdcc_pkg::RES_DEPTH) - cnt_r;

endmodule

`default_nettype wire

### rtl/cdcc_back.sv
// back end: per-key time tables, click classification and result generation
`default_nettype none
`include "click_double_click_classifier_top_defines.svh"

module cdcc_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               op_valid,
  input  wire cdcc_pkg::op_t                      op_head,
  output logic                                    op_pop,
  input  wire cdcc_pkg::cfg_t                     cfg,
  input  wire logic [cdcc_pkg::RES_CNT_BITS-1:0]  res_free,
  output logic                                    clr_busy,
  output logic                                    push0,
  output logic                                    push1,
  output cdcc_pkg::res_t                          res0,
  output cdcc_pkg::res_t                          res1
);

  localparam int TB = cdcc_pkg::TIME_BITS;
  localparam int SB = cdcc_pkg::SLOT_BITS;
  localparam int PB = cdcc_pkg::POS_BITS;

  logic [SB:0]                 clr_cnt_r, clr_cnt_nxt;
  logic                        b_valid_r;
  cdcc_pkg::op_t               b_op_r;
  logic signed [PB-1:0]        click_x_r, click_x_nxt;
  logic signed [PB-1:0]        click_y_r, click_y_nxt;

  logic [TB-1:0]               press_rd;
  logic [TB:0]                 rel_rd;
  logic [SB-1:0]               b_slot;
  logic                        press_we;
  logic                        rel_we;
  logic [TB:0]                 rel_wdata;
  logic                        ram_rel_we;
  logic [SB-1:0]               ram_rel_waddr;
  logic [TB:0]                 ram_rel_wdata;

  logic [TB-1:0]               held;
  logic [TB-1:0]               gap;
  logic [cdcc_pkg::TICK_BITS-1:0] limit;
  logic                        is_click;
  logic                        dbl_time;
  logic signed [PB:0]          dx, dy;
  logic signed [2*PB+1:0]      dx2, dy2;
  logic [cdcc_pkg::D2_BITS-1:0] d2;
  logic                        near;
  logic                        dbl;
  logic [1:0]                  b_nres;
  logic [cdcc_pkg::RES_CNT_BITS-1:0] need;

  // clearing pass over the release table after reset
  assign clr_busy    = !clr_cnt_r[SB];
  assign clr_cnt_nxt = clr_busy ? clr_cnt_r + (SB+1)'(1) : clr_cnt_r;

  // room for what stage b pushes now plus two for the op entering
  always_comb begin
    b_nres = 2'd0;
    if (b_valid_r) begin
      b_nres = (b_op_r.kind == cdcc_pkg::OP_RELEASE) ? 2'd2 : 2'd1;
    end
  end
  assign need   = cdcc_pkg::RES_CNT_BITS'(2) + cdcc_pkg::RES_CNT_BITS'(b_nres);
  assign op_pop = op_valid && !clr_busy && (res_free >= need);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      b_valid_r <= 1'b0;
      click_x_r <= '0;
      click_y_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      b_valid_r <= op_pop;
      click_x_r <= click_x_nxt;
      click_y_r <= click_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      b_op_r <= op_head;
    end
  end

  assign b_slot = b_op_r.key[SB-1:0];

  cdcc_ram #(.WIDTH(TB), .DEPTH(cdcc_pkg::KEY_SLOTS)) u_press_ram (
    .clk   (clk),
    .we    (press_we),
    .waddr (b_slot),
    .wdata (b_op_r.now),
    .re    (op_pop),
    .raddr (op_head.key[SB-1:0]),
    .rdata (press_rd)
  );

  // release word: valid mark on top of the release time
  assign ram_rel_we    = clr_busy || rel_we;
  assign ram_rel_waddr = clr_busy ? clr_cnt_r[SB-1:0] : b_slot;
  assign ram_rel_wdata = clr_busy ? '0 : rel_wdata;

  cdcc_ram #(.WIDTH(TB+1), .DEPTH(cdcc_pkg::KEY_SLOTS)) u_rel_ram (
    .clk   (clk),
    .we    (ram_rel_we),
    .waddr (ram_rel_waddr),
    .wdata (ram_rel_wdata),
    .re    (op_pop),
    .raddr (op_head.key[SB-1:0]),
    .rdata (rel_rd)
  );

  // classification
  always_comb begin
    limit    = b_op_r.mouse ? cfg.mouse_click : cfg.key_click;
    held     = b_op_r.now - press_rd;
    gap      = b_op_r.now - rel_rd[TB-1:0];
    is_click = held < {{(TB-cdcc_pkg::TICK_BITS){1'b0}}, limit};
    dbl_time = rel_rd[TB] && (gap < {{(TB-cdcc_pkg::TICK_BITS){1'b0}}, cfg.dbl_click});
    dx       = {click_x_r[PB-1], click_x_r} - {b_op_r.cx[PB-1], b_op_r.cx};
    dy       = {click_y_r[PB-1], click_y_r} - {b_op_r.cy[PB-1], b_op_r.cy};
    dx2      = dx * dx;
    dy2      = dy * dy;
    d2       = unsigned'(dx2) + unsigned'(dy2);
    near     = d2 < {{(cdcc_pkg::D2_BITS-cdcc_pkg::TICK_BITS){1'b0}}, cfg.radius_sq};
    dbl      = dbl_time && (!b_op_r.mouse || near);
  end

  always_comb begin
    push0       = 1'b0;
    push1       = 1'b0;
    press_we    = 1'b0;
    rel_we      = 1'b0;
    rel_wdata   = {1'b1, b_op_r.now};
    click_x_nxt = click_x_r;
    click_y_nxt = click_y_r;
    res0.kind   = cdcc_pkg::EV_DOWN;
    res0.key    = b_op_r.key;
    res0.mods   = b_op_r.mods;
    res0.last   = 1'b1;
    res1.kind   = dbl ? cdcc_pkg::EV_DOUBLE : cdcc_pkg::EV_CLICK;
    res1.key    = b_op_r.key;
    res1.mods   = '0;
    res1.last   = 1'b1;
    if (b_valid_r) begin
      case (b_op_r.kind)
        cdcc_pkg::OP_PRESS: begin
          push0    = 1'b1;
          press_we = 1'b1;
        end
        cdcc_pkg::OP_REPEAT: begin
          push0 = 1'b1;
        end
        cdcc_pkg::OP_RELEASE: begin
          push0     = 1'b1;
          res0.kind = cdcc_pkg::EV_RELEASE;
          res0.mods = '0;
          res0.last = !is_click;
          push1     = is_click;
          rel_we    = 1'b1;
          if (is_click && dbl) begin
            // double click drops the mark so a third click starts over
            rel_wdata = {1'b0, rel_rd[TB-1:0]};
          end else if (is_click && b_op_r.mouse) begin
            click_x_nxt = b_op_r.cx;
            click_y_nxt = b_op_r.cy;
          end
        end
        default: begin
          push0 = 1'b0;
        end
      endcase
    end
  end

  `CDCC_HOLDS(a_clear_excl_b, clr_busy, !b_valid_r)
  `CDCC_HOLDS(a_res_room, b_valid_r, res_free >= cdcc_pkg::RES_CNT_BITS'(b_nres))
  `CDCC_HOLDS(a_pair_order, push1, push0 && !res0.last)
  `CDCC_NEXT(a_clear_once, !clr_busy, !clr_busy)

endmodule

`default_nettype wire

### rtl/click_double_click_classifier_top.sv
// top level of the click and double click classifier: register port and block wiring
`default_nettype none

// path: an accepted word passes the op queue, back stage register and result queue
// throughput: one event per cycle while full is low and the result queue has room;
// a release gives two result words, and the result queue hands out one per cycle
// reset: registers take their reset values, then a clearing pass over every entry
// of the release table holds full high; register writes are taken meanwhile
module click_double_click_classifier_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input event queue side
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [1:0]                           in_cmd,
  input  wire logic                                 in_from_mouse,
  input  wire logic [cdcc_pkg::KEY_BITS-1:0]        in_key_code,
  input  wire logic [cdcc_pkg::MOD_BITS-1:0]        in_modifiers,
  input  wire logic [cdcc_pkg::TIME_BITS-1:0]       in_now_ticks,
  input  wire logic signed [cdcc_pkg::POS_BITS-1:0] in_cursor_x,
  input  wire logic signed [cdcc_pkg::POS_BITS-1:0] in_cursor_y,
  // result queue side
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [1:0]                                out_event_kind,
  output logic [cdcc_pkg::KEY_BITS-1:0]             out_event_key,
  output logic [cdcc_pkg::MOD_BITS-1:0]             out_event_modifiers,
  output logic                                      out_last,
  // register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [cdcc_pkg::ADDR_BITS-1:0]       paddr,
  input  wire logic [cdcc_pkg::DATA_BITS-1:0]       pwdata,
  output logic [cdcc_pkg::DATA_BITS-1:0]            prdata,
  output logic                                      pready
);

  localparam int TK = cdcc_pkg::TICK_BITS;
  localparam int DB = cdcc_pkg::DATA_BITS;

  // configuration registers
  logic           listening_r;
  logic [TK-1:0]  key_click_r;
  logic [TK-1:0]  mouse_click_r;
  logic [TK-1:0]  dbl_click_r;
  logic [TK-1:0]  radius_sq_r;
  logic           reg_wr;
  logic [2:0]     reg_idx;
  cdcc_pkg::cfg_t cfg;

  // front to back op queue
  logic           op_valid;
  logic           op_pop;
  cdcc_pkg::op_t  op_head;
  logic           clr_busy;

  // back to result queue
  logic                              push0;
  logic                              push1;
  cdcc_pkg::res_t                    res0;
  cdcc_pkg::res_t                    res1;
  cdcc_pkg::res_t                    res_head;
  logic [cdcc_pkg::RES_CNT_BITS-1:0] res_free;

  // register port: always ready, write on the access phase
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[cdcc_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listening_r   <= 1'b1;
      key_click_r   <= TK'(100);
      mouse_click_r <= TK'(150);
      dbl_click_r   <= TK'(250);
      radius_sq_r   <= TK'(5);
    end else if (reg_wr) begin
      case (reg_idx)
        cdcc_pkg::REG_LISTENING:    listening_r   <= pwdata[0];
        cdcc_pkg::REG_KEY_CLICK:    key_click_r   <= pwdata[TK-1:0];
        cdcc_pkg::REG_MOUSE_CLICK:  mouse_click_r <= pwdata[TK-1:0];
        cdcc_pkg::REG_DOUBLE_CLICK: dbl_click_r   <= pwdata[TK-1:0];
        cdcc_pkg::REG_RADIUS_SQ:    radius_sq_r   <= pwdata[TK-1:0];
        default: begin
          // addresses past the list are dropped
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      cdcc_pkg::REG_LISTENING:    prdata = {{(DB-1){1'b0}}, listening_r};
      cdcc_pkg::REG_KEY_CLICK:    prdata = {{(DB-TK){1'b0}}, key_click_r};
      cdcc_pkg::REG_MOUSE_CLICK:  prdata = {{(DB-TK){1'b0}}, mouse_click_r};
      cdcc_pkg::REG_DOUBLE_CLICK: prdata = {{(DB-TK){1'b0}}, dbl_click_r};
      cdcc_pkg::REG_RADIUS_SQ:    prdata = {{(DB-TK){1'b0}}, radius_sq_r};
      default:                    prdata = '0;
    endcase
  end

  assign cfg.key_click   = key_click_r;
  assign cfg.mouse_click = mouse_click_r;
  assign cfg.dbl_click   = dbl_click_r;
  assign cfg.radius_sq   = radius_sq_r;

  // front: accept, drop ignored events, two-entry op queue
  cdcc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd        (in_cmd),
    .in_from_mouse (in_from_mouse),
    .in_key_code   (in_key_code),
    .in_modifiers  (in_modifiers),
    .in_now_ticks  (in_now_ticks),
    .in_cursor_x   (in_cursor_x),
    .in_cursor_y   (in_cursor_y),
    .listening     (listening_r),
    .clr_busy      (clr_busy),
    .op_pop        (op_pop),
    .op_valid      (op_valid),
    .op_head       (op_head)
  );

  // back: table read at pop, classify and write back in the following cycle
  cdcc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_head  (op_head),
    .op_pop   (op_pop),
    .cfg      (cfg),
    .res_free (res_free),
    .clr_busy (clr_busy),
    .push0    (push0),
    .push1    (push1),
    .res0     (res0),
    .res1     (res1)
  );

  // result words wait here until popped
  cdcc_res_queue u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (push0),
    .push1 (push1),
    .res0  (res0),
    .res1  (res1),
    .pop   (pop),
    .empty (empty),
    .head  (res_head),
    .free  (res_free)
  );

  assign out_event_kind      = res_head.kind;
  assign out_event_key       = res_head.key;
  assign out_event_modifiers = res_head.mods;
  assign out_last            = res_head.last;

endmodule

`default_nettype wire
